// ===== sv/iimdsp_pkg.sv =====
package iimdsp_pkg;

   localparam int LENGTH_BITS = 48;
   localparam int EXT_COUNT_BITS = 15;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] MARKER_BYTE = 8'h1C;
   localparam logic [7:0] DESIG_BYTE0 = 8'h1B;
   localparam logic [7:0] DESIG_BYTE1 = 8'h25;
   localparam logic [7:0] DESIG_BYTE2 = 8'h47;
   localparam logic [1:0] DESIG_DONE = 2'd3;

   // event codes
   localparam logic [3:0] EV_HEADER      = 4'd0;
   localparam logic [3:0] EV_HEADER_DONE = 4'd1;
   localparam logic [3:0] EV_EMPTY       = 4'd2;
   localparam logic [3:0] EV_PAYLOAD     = 4'd3;
   localparam logic [3:0] EV_LAST        = 4'd4;
   localparam logic [3:0] EV_PAD         = 4'd5;
   localparam logic [3:0] EV_TRUNC       = 4'd6;
   localparam logic [3:0] EV_BAD_MARKER  = 4'd7;
   localparam logic [3:0] EV_LEN_ERR     = 4'd8;
   localparam logic [3:0] EV_IGNORED     = 4'd9;

   // handling classes
   localparam logic [1:0] CLS_SKIP    = 2'd0;
   localparam logic [1:0] CLS_TEXT    = 2'd1;
   localparam logic [1:0] CLS_VALUE16 = 2'd2;
   localparam logic [1:0] CLS_CHARSET = 2'd3;

   localparam logic [7:0] REC_TEXT_LO = 8'd2;
   localparam logic [7:0] REC_TEXT_HI = 8'd6;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_data;
   } req_type;

   typedef struct packed {
      logic [3:0]             event_res;
      logic [7:0]             record_number;
      logic [7:0]             dataset_number;
      logic [LENGTH_BITS-1:0] data_length;
      logic [7:0]             payload_byte;
      logic [1:0]             handling_class;
      logic                   known_dataset;
      logic                   text_utf8;
      logic [15:0]            word_value;
      logic                   word_valid;
   } rsp_type;

   typedef struct packed {
      logic known;
      logic [1:0] cls;
   } lookup_type;

   // classified byte handed from front to back
   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_data;
      logic       is_marker;
      logic       is_zero;
      lookup_type lookup;
      logic [3:0] desig_eq;
   } item_type;

   typedef enum logic [7:0] {
      PH_MARKER  = 8'b0000_0001,
      PH_RECORD  = 8'b0000_0010,
      PH_DATASET = 8'b0000_0100,
      PH_LEN_HI  = 8'b0000_1000,
      PH_LEN_LO  = 8'b0001_0000,
      PH_EXT_LEN = 8'b0010_0000,
      PH_PAYLOAD = 8'b0100_0000,
      PH_STOPPED = 8'b1000_0000
   } phase_type;

   // known record:dataset pairs; unknown record-2 datasets count as text
   function automatic lookup_type ds_lookup(input logic [7:0] rec, input logic [7:0] ds);
      lookup_type r;
      r.known = 1'b1;
      r.cls = CLS_SKIP;
      unique case (rec)
         8'd1: begin
            unique case (ds)
               8'd0, 8'd20, 8'd22, 8'd120, 8'd122: r.cls = CLS_VALUE16;
               8'd90: r.cls = CLS_CHARSET;
               8'd5, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd100: r.cls = CLS_TEXT;
               default: r.known = 1'b0;
            endcase
         end
         8'd2: begin
            unique case (ds)
               8'd0, 8'd200, 8'd201: r.cls = CLS_VALUE16;
               8'd125, 8'd202: r.cls = CLS_SKIP;
               8'd3, 8'd4, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12, 8'd15, 8'd20, 8'd22, 8'd25,
               8'd26, 8'd27, 8'd30, 8'd35, 8'd37, 8'd38, 8'd40, 8'd42, 8'd45, 8'd47,
               8'd50, 8'd55, 8'd60, 8'd62, 8'd63, 8'd65, 8'd70, 8'd75, 8'd80, 8'd85,
               8'd90, 8'd92, 8'd95, 8'd100, 8'd101, 8'd103, 8'd105, 8'd110, 8'd115,
               8'd116, 8'd118, 8'd120, 8'd122, 8'd130, 8'd131, 8'd135, 8'd150, 8'd151,
               8'd152, 8'd153, 8'd154: r.cls = CLS_TEXT;
               default: begin
                  r.known = 1'b0;
                  r.cls = CLS_TEXT;
               end
            endcase
         end
         8'd7: begin
            unique case (ds)
               8'd10, 8'd20, 8'd90, 8'd95: r.cls = CLS_SKIP;
               default: r.known = 1'b0;
            endcase
         end
         8'd8, 8'd9: begin
            r.known = (ds == 8'd10);
         end
         default: r.known = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/iimdsp_front.sv =====
module iimdsp_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  iimdsp_pkg::req_type  req_payload,
   input  logic                 q_full,
   output logic                 q_push,
   output iimdsp_pkg::item_type q_item
);
   import iimdsp_pkg::*;

   logic [7:0] prev_byte_ff;
   logic [7:0] prev_byte_in;

   assign req_ready = !q_full && !reset;
   assign q_push = req_valid && req_ready;

   // remember the byte before, so the dataset byte can be classified here
   assign prev_byte_in = q_push ? req_payload.in_byte : prev_byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_byte_ff <= '0;
      end else begin
         prev_byte_ff <= prev_byte_in;
      end
   end

   always_comb begin
      q_item.in_byte = req_payload.in_byte;
      q_item.end_of_data = req_payload.end_of_data;
      q_item.is_marker = (req_payload.in_byte == MARKER_BYTE);
      q_item.is_zero = (req_payload.in_byte == 8'd0);
      q_item.lookup = ds_lookup(prev_byte_ff, req_payload.in_byte);
      q_item.desig_eq = {1'b0,
                         req_payload.in_byte == DESIG_BYTE2,
                         req_payload.in_byte == DESIG_BYTE1,
                         req_payload.in_byte == DESIG_BYTE0};
   end

endmodule

// ===== sv/iimdsp_queue.sv =====
module iimdsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  iimdsp_pkg::item_type push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output iimdsp_pkg::item_type head_item
);
   import iimdsp_pkg::*;

   item_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;

   assign full = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + QUEUE_CNT_BITS'(push) - QUEUE_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("queue read while empty");
`endif

endmodule

// ===== sv/iimdsp_back.sv =====
module iimdsp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  iimdsp_pkg::item_type head_item,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output iimdsp_pkg::rsp_type  rsp_payload
);
   import iimdsp_pkg::*;

   phase_type                 phase_ff, phase_in;
   logic [7:0]                rec_ff, rec_in;
   logic [7:0]                ds_ff, ds_in;
   logic [7:0]                len_hi_ff, len_hi_in;
   logic [LENGTH_BITS-1:0]    acc_ff, acc_in;
   logic [EXT_COUNT_BITS-1:0] ext_left_ff, ext_left_in;
   logic [LENGTH_BITS-1:0]    left_ff, left_in;
   logic [1:0]                pidx_ff, pidx_in;
   logic                      utf8_ff, utf8_in;
   logic                      seen_ff, seen_in;
   logic [1:0]                cls_ff, cls_in;
   logic                      known_ff, known_in;
   logic [7:0]                hold_ff, hold_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_type                   rsp_ff, rsp_in;

   logic [7:0]             b;
   logic [3:0]             ev;
   logic [7:0]             pbyte;
   logic [15:0]            word;
   logic                   wvalid;
   logic                   hdr_done;
   logic [LENGTH_BITS-1:0] left_dec;
   logic [LENGTH_BITS-1:0] ext_acc;

   // take the next byte when the output register is free or being drained
   assign pop = head_valid && (!rsp_valid_ff || rsp_ready);
   assign b = head_item.in_byte;
   assign left_dec = left_ff - 1'b1;
   assign ext_acc = {acc_ff[LENGTH_BITS-9:0], b};

   always_comb begin
      phase_in = phase_ff;
      rec_in = rec_ff;
      ds_in = ds_ff;
      len_hi_in = len_hi_ff;
      acc_in = acc_ff;
      ext_left_in = ext_left_ff;
      left_in = left_ff;
      pidx_in = pidx_ff;
      utf8_in = utf8_ff;
      seen_in = seen_ff;
      cls_in = cls_ff;
      known_in = known_ff;
      hold_in = hold_ff;
      ev = EV_IGNORED;
      pbyte = '0;
      word = '0;
      wvalid = 1'b0;
      hdr_done = 1'b0;
      unique case (phase_ff)
         PH_MARKER: begin
            if (head_item.is_marker) begin
               rec_in = '0;
               ds_in = '0;
               cls_in = CLS_SKIP;
               known_in = 1'b0;
               acc_in = '0;
               phase_in = PH_RECORD;
               ev = EV_HEADER;
            end else if (head_item.is_zero && seen_ff) begin
               ev = head_item.end_of_data ? EV_PAD : EV_TRUNC;
               phase_in = PH_STOPPED;
            end else begin
               ev = EV_BAD_MARKER;
               phase_in = PH_STOPPED;
            end
         end
         PH_RECORD: begin
            rec_in = b;
            phase_in = PH_DATASET;
            ev = EV_HEADER;
         end
         PH_DATASET: begin
            ds_in = b;
            cls_in = head_item.lookup.cls;
            known_in = head_item.lookup.known;
            phase_in = PH_LEN_HI;
            ev = EV_HEADER;
         end
         PH_LEN_HI: begin
            len_hi_in = b;
            phase_in = PH_LEN_LO;
            ev = EV_HEADER;
         end
         PH_LEN_LO: begin
            if (!len_hi_ff[7]) begin
               acc_in = LENGTH_BITS'({len_hi_ff, b});
               hdr_done = 1'b1;
            end else if ({len_hi_ff[6:0], b} == '0) begin
               acc_in = '0;
               hdr_done = 1'b1;
            end else begin
               ext_left_in = {len_hi_ff[6:0], b};
               acc_in = '0;
               phase_in = PH_EXT_LEN;
               ev = EV_HEADER;
            end
         end
         PH_EXT_LEN: begin
            if (acc_ff[LENGTH_BITS-1 -: 8] != 8'd0) begin
               ev = EV_LEN_ERR;
               phase_in = PH_STOPPED;
            end else begin
               acc_in = ext_acc;
               ext_left_in = ext_left_ff - 1'b1;
               if (ext_left_ff == EXT_COUNT_BITS'(1)) begin
                  hdr_done = 1'b1;
               end else begin
                  ev = EV_HEADER;
               end
            end
         end
         PH_PAYLOAD: begin
            pbyte = b;
            if (cls_ff == CLS_CHARSET && pidx_ff != DESIG_DONE) begin
               if (head_item.desig_eq[pidx_ff]) begin
                  pidx_in = pidx_ff + 1'b1;
                  if (pidx_ff == 2'd2) begin
                     utf8_in = 1'b1;
                  end
               end else begin
                  pidx_in = DESIG_DONE;
               end
            end
            if (cls_ff == CLS_VALUE16 && acc_ff == LENGTH_BITS'(2)) begin
               if (left_ff == LENGTH_BITS'(2)) begin
                  hold_in = b;
               end else if (left_ff == LENGTH_BITS'(1)) begin
                  word = {hold_ff, b};
                  wvalid = 1'b1;
               end
            end
            left_in = left_dec;
            if (left_dec == '0) begin
               ev = EV_LAST;
               seen_in = 1'b1;
               phase_in = PH_MARKER;
            end else begin
               ev = EV_PAYLOAD;
            end
         end
         PH_STOPPED: ev = EV_IGNORED;
         default: ev = EV_IGNORED;
      endcase
      if (hdr_done) begin
         if (cls_ff == CLS_CHARSET) begin
            utf8_in = 1'b0;
         end
         if (acc_in == '0) begin
            seen_in = 1'b1;
            phase_in = PH_MARKER;
            ev = EV_EMPTY;
         end else begin
            left_in = acc_in;
            pidx_in = '0;
            phase_in = PH_PAYLOAD;
            ev = EV_HEADER_DONE;
         end
      end
   end

   always_comb begin
      rsp_in.event_res = ev;
      rsp_in.record_number = rec_in;
      rsp_in.dataset_number = ds_in;
      rsp_in.data_length = acc_in;
      rsp_in.payload_byte = pbyte;
      rsp_in.handling_class = cls_in;
      rsp_in.known_dataset = known_in;
      rsp_in.text_utf8 = utf8_in && rec_in >= REC_TEXT_LO && rec_in <= REC_TEXT_HI;
      rsp_in.word_value = word;
      rsp_in.word_valid = wvalid;
      rsp_valid_in = pop || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset || (pop && head_item.end_of_data)) begin
         phase_ff <= PH_MARKER;
         rec_ff <= '0;
         ds_ff <= '0;
         len_hi_ff <= '0;
         acc_ff <= '0;
         ext_left_ff <= '0;
         left_ff <= '0;
         pidx_ff <= '0;
         utf8_ff <= 1'b0;
         seen_ff <= 1'b0;
         cls_ff <= CLS_SKIP;
         known_ff <= 1'b0;
         hold_ff <= '0;
      end else if (pop) begin
         phase_ff <= phase_in;
         rec_ff <= rec_in;
         ds_ff <= ds_in;
         len_hi_ff <= len_hi_in;
         acc_ff <= acc_in;
         ext_left_ff <= ext_left_in;
         left_ff <= left_in;
         pidx_ff <= pidx_in;
         utf8_ff <= utf8_in;
         seen_ff <= seen_in;
         cls_ff <= cls_in;
         known_ff <= known_in;
         hold_ff <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef SYNTHESIS
   a_payload_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> left_ff != '0)
      else $error("payload phase with nothing left to count");
   a_end_restarts: assert property (@(posedge clock) disable iff (reset)
      pop && head_item.end_of_data |=> phase_ff == PH_MARKER && !seen_ff)
      else $error("parser did not restart after end of data");
   a_word_on_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.word_valid |-> rsp_ff.event_res == EV_LAST)
      else $error("word completed on a byte that is not the last payload byte");
`endif

endmodule

// ===== sv/iim_dataset_stream_parser_core.sv =====
// IPTC-IIM dataset stream parser. Feed the stream one byte per transfer on req_;
// every byte yields exactly one result transfer on rsp_, in order. A dataset is the
// 0x1C marker, record, dataset, a 16-bit length word and, for extended lengths,
// that many further length bytes (values of 2^48 and above give a length error),
// then the payload. Each record:dataset pair is looked up in a constant table for
// its handling class; dataset 1:90 beginning ESC % G switches records 2..6 to UTF-8.
// After a bad marker, a truncation, end padding or a length error the parser
// reports every further byte as ignored until the byte flagged end_of_data, after
// which it starts over. Rate: one byte per cycle sustained while rsp_ready stays high;
// the back end's state update is the only loop. A byte goes from its req_ transfer
// into the two-entry queue between the classifying front end and the parsing back
// end, and from the queue head into the output register that drives rsp_valid.
// Either side may stall without losing a byte; req_ready drops only when the
// queue holds two bytes or reset is high.
module iim_dataset_stream_parser_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  iimdsp_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output iimdsp_pkg::rsp_type rsp_payload
);
   import iimdsp_pkg::*;

   logic     q_full;
   logic     q_push;
   item_type q_item;
   logic     head_valid;
   item_type head_item;
   logic     pop;

   // classify: marker and zero tests, table lookup on the previous and current byte
   iimdsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_item)
   );

   // hold classified bytes so front and back stall independently
   iimdsp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (q_item),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // advance the dataset state machine and register one result per byte
   iimdsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (head_valid),
      .head_item   (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== tb/sv/iim_dataset_stream_parser_core_tb.sv =====
`timescale 1ns / 100ps

module iim_dataset_stream_parser_core_tb;
   import iimdsp_pkg::*;

   // Clock, reset and the two channels. Every input starts at a known value.
   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready   = 1'b0;
   rsp_type rsp_payload;

   iim_dataset_stream_parser_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Idle rates in percent per cycle, and a long receiver hold-off counted down
   // by the result process.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_off_left  = 0;
   int mismatches     = 0;

   // Results the parser owes us, oldest first; bytes of the stream being sent.
   rsp_type    parse_due[$];
   logic [7:0] stream_bytes[$];

   // ------------------------------------------------------------------
   // Parser state as we predict it
   // ------------------------------------------------------------------
   phase_type              m_phase;
   logic [7:0]             m_rec, m_ds, m_len_hi, m_word_hi;
   logic [LENGTH_BITS-1:0] m_len, m_pay_left;
   logic [14:0]            m_ext_left;
   logic [1:0]             m_desig_idx, m_cls;
   logic                   m_utf8, m_seen, m_known;

   function automatic void parser_clear();
      m_phase     = PH_MARKER;
      m_rec       = '0;
      m_ds        = '0;
      m_len_hi    = '0;
      m_word_hi   = '0;
      m_len       = '0;
      m_pay_left  = '0;
      m_ext_left  = '0;
      m_desig_idx = '0;
      m_cls       = CLS_SKIP;
      m_utf8      = 1'b0;
      m_seen      = 1'b0;
      m_known     = 1'b0;
   endfunction

   // Known record:dataset pairs, returned as {known, class}. Pairs missing from
   // the list are unknown; in record 2 they still count as text.
   function automatic logic [2:0] pair_class(input logic [7:0] rec, input logic [7:0] ds);
      logic [1:0] cls;
      logic       hit;
      hit = 1'b1;
      cls = CLS_SKIP;
      case (rec)
         8'd1: begin
            case (ds)
               8'd0, 8'd20, 8'd22, 8'd120, 8'd122: cls = CLS_VALUE16;
               8'd90: cls = CLS_CHARSET;
               8'd5, 8'd30, 8'd40, 8'd50, 8'd60, 8'd70, 8'd80, 8'd100: cls = CLS_TEXT;
               default: hit = 1'b0;
            endcase
         end
         8'd2: begin
            cls = CLS_TEXT;
            case (ds)
               8'd0, 8'd200, 8'd201: cls = CLS_VALUE16;
               8'd125, 8'd202: cls = CLS_SKIP;
               8'd3, 8'd4, 8'd5, 8'd7, 8'd8, 8'd10, 8'd12, 8'd15, 8'd20, 8'd22,
               8'd25, 8'd26, 8'd27, 8'd30, 8'd35, 8'd37, 8'd38, 8'd40, 8'd42,
               8'd45, 8'd47, 8'd50, 8'd55, 8'd60, 8'd62, 8'd63, 8'd65, 8'd70,
               8'd75, 8'd80, 8'd85, 8'd90, 8'd92, 8'd95, 8'd100, 8'd101, 8'd103,
               8'd105, 8'd110, 8'd115, 8'd116, 8'd118, 8'd120, 8'd122, 8'd130,
               8'd131, 8'd135, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154: ;
               default: hit = 1'b0;
            endcase
         end
         8'd7: hit = (ds == 8'd10 || ds == 8'd20 || ds == 8'd90 || ds == 8'd95);
         8'd8, 8'd9: hit = (ds == 8'd10);
         default: hit = 1'b0;
      endcase
      return {hit, cls};
   endfunction

   // Header complete with its final length: either an empty dataset or the
   // start of the payload. A charset designation header drops UTF-8 first.
   function automatic logic [3:0] close_header();
      if (m_cls == CLS_CHARSET) m_utf8 = 1'b0;
      if (m_len == 0) begin
         m_seen  = 1'b1;
         m_phase = PH_MARKER;
         return EV_EMPTY;
      end
      m_pay_left  = m_len;
      m_desig_idx = '0;
      m_phase     = PH_PAYLOAD;
      return EV_HEADER_DONE;
   endfunction

   // Advance the predicted parser by one byte and return the result it owes.
   function automatic rsp_type iim_parse(input logic [7:0] b, input logic eod);
      rsp_type                r;
      logic [15:0]            word;
      logic [LENGTH_BITS+7:0] widened;
      logic [7:0]             desig;
      r = '0;
      r.event_res = EV_IGNORED;
      case (m_phase)
         PH_MARKER: begin
            if (b == MARKER_BYTE) begin
               m_rec       = '0;
               m_ds        = '0;
               m_cls       = CLS_SKIP;
               m_known     = 1'b0;
               m_len       = '0;
               m_phase     = PH_RECORD;
               r.event_res = EV_HEADER;
            end else if (b == 8'h00 && m_seen) begin
               // zero after a complete dataset: padding on the last byte only
               r.event_res = eod ? EV_PAD : EV_TRUNC;
               m_phase     = PH_STOPPED;
            end else begin
               r.event_res = EV_BAD_MARKER;
               m_phase     = PH_STOPPED;
            end
         end
         PH_RECORD: begin
            m_rec       = b;
            m_phase     = PH_DATASET;
            r.event_res = EV_HEADER;
         end
         PH_DATASET: begin
            m_ds               = b;
            {m_known, m_cls}   = pair_class(m_rec, b);
            m_phase            = PH_LEN_HI;
            r.event_res        = EV_HEADER;
         end
         PH_LEN_HI: begin
            m_len_hi    = b;
            m_phase     = PH_LEN_LO;
            r.event_res = EV_HEADER;
         end
         PH_LEN_LO: begin
            word = {m_len_hi, b};
            m_len = '0;
            if (!word[15]) begin
               m_len[15:0] = word;
               r.event_res = close_header();
            end else if (word[14:0] == 15'd0) begin
               // extended length with no length bytes: empty payload
               r.event_res = close_header();
            end else begin
               m_ext_left  = word[14:0];
               m_phase     = PH_EXT_LEN;
               r.event_res = EV_HEADER;
            end
         end
         PH_EXT_LEN: begin
            widened = {m_len, b};
            if (widened[LENGTH_BITS+7:LENGTH_BITS] != 8'd0) begin
               // keep the length gathered before the overflowing byte
               r.event_res = EV_LEN_ERR;
               m_phase     = PH_STOPPED;
            end else begin
               m_len       = widened[LENGTH_BITS-1:0];
               m_ext_left  = m_ext_left - 15'd1;
               r.event_res = (m_ext_left == 15'd0) ? close_header() : EV_HEADER;
            end
         end
         PH_PAYLOAD: begin
            r.payload_byte = b;
            if (m_cls == CLS_CHARSET && m_desig_idx != DESIG_DONE) begin
               desig = (m_desig_idx == 2'd0) ? DESIG_BYTE0 :
                       (m_desig_idx == 2'd1) ? DESIG_BYTE1 : DESIG_BYTE2;
               if (b == desig) begin
                  m_desig_idx = m_desig_idx + 2'd1;
                  if (m_desig_idx == DESIG_DONE) m_utf8 = 1'b1;
               end else begin
                  m_desig_idx = DESIG_DONE;
               end
            end
            if (m_cls == CLS_VALUE16 && m_len == 2) begin
               if (m_pay_left == 2) begin
                  m_word_hi = b;
               end else if (m_pay_left == 1) begin
                  r.word_value = {m_word_hi, b};
                  r.word_valid = 1'b1;
               end
            end
            m_pay_left = m_pay_left - 1;
            if (m_pay_left == 0) begin
               r.event_res = EV_LAST;
               m_seen      = 1'b1;
               m_phase     = PH_MARKER;
            end else begin
               r.event_res = EV_PAYLOAD;
            end
         end
         default: r.event_res = EV_IGNORED;
      endcase
      r.record_number  = m_rec;
      r.dataset_number = m_ds;
      r.data_length    = m_len;
      r.handling_class = m_cls;
      r.known_dataset  = m_known;
      r.text_utf8      = m_utf8 && m_rec >= REC_TEXT_LO && m_rec <= REC_TEXT_HI;
      // the last byte of a stream puts the parser back to its start
      if (eod) parser_clear();
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Result channel: check each transfer against the oldest prediction,
   // then pick the ready for the next cycle.
   // ------------------------------------------------------------------
   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (parse_due.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_payload);
            mismatches++;
         end else begin
            want = parse_due.pop_front();
            check_field("event_res", 64'(want.event_res), 64'(rsp_payload.event_res));
            check_field("record_number", 64'(want.record_number),
                        64'(rsp_payload.record_number));
            check_field("dataset_number", 64'(want.dataset_number),
                        64'(rsp_payload.dataset_number));
            check_field("data_length", 64'(want.data_length), 64'(rsp_payload.data_length));
            check_field("payload_byte", 64'(want.payload_byte),
                        64'(rsp_payload.payload_byte));
            check_field("handling_class", 64'(want.handling_class),
                        64'(rsp_payload.handling_class));
            check_field("known_dataset", 64'(want.known_dataset),
                        64'(rsp_payload.known_dataset));
            check_field("text_utf8", 64'(want.text_utf8), 64'(rsp_payload.text_utf8));
            check_field("word_value", 64'(want.word_value), 64'(rsp_payload.word_value));
            check_field("word_valid", 64'(want.word_valid), 64'(rsp_payload.word_valid));
         end
      end
      // Hold ready low through a requested hold-off, else stall at random.
      if (hold_off_left != 0) begin
         hold_off_left <= hold_off_left - 1;
         rsp_ready     <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------
   // Offer one byte and hold it until the transfer; predict its result then.
   // Valid drops only when an idle gap is chosen, never between back-to-back bytes.
   task automatic send_byte(input logic [7:0] data, input logic last);
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= {data, last};
      do @(posedge clock); while (!req_ready);
      parse_due.push_back(iim_parse(data, last));
   endtask

   // Send the built stream, flagging its final byte as end of data.
   task automatic send_stream();
      for (int i = 0; i < stream_bytes.size(); i++)
         send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
   endtask

   // Drop valid and hold off until every predicted result has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (parse_due.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      send_idle_pct  = sender_pct;
      recv_stall_pct = receiver_pct;
   endtask

   // ------------------------------------------------------------------
   // Stream generation
   // ------------------------------------------------------------------
   // Append one dataset. ext_count below zero selects a plain 15-bit length;
   // otherwise the length travels in ext_count big-endian bytes. At most
   // payload_cap payload bytes go out, so huge lengths end mid-payload.
   task automatic add_dataset(input logic [7:0] rec, input logic [7:0] ds,
                              input logic [63:0] len, input int ext_count,
                              input int payload_cap);
      logic [15:0] word;
      int          n_pay;
      int          brk;
      stream_bytes.push_back(MARKER_BYTE);
      stream_bytes.push_back(rec);
      stream_bytes.push_back(ds);
      if (ext_count < 0) word = len[15:0];
      else word = {1'b1, ext_count[14:0]};
      stream_bytes.push_back(word[15:8]);
      stream_bytes.push_back(word[7:0]);
      for (int i = ext_count - 1; i >= 0; i--)
         stream_bytes.push_back(8'(len >> (8 * i)));
      n_pay = (len > 64'(payload_cap)) ? payload_cap : int'(len);
      // Charset designation: often lead with ESC % G, sometimes break it off early.
      brk = -1;
      if (rec == 8'd1 && ds == 8'd90 && $urandom_range(0, 3) != 0)
         brk = $urandom_range(0, 1) ? 3 : int'($urandom_range(0, 2));
      for (int i = 0; i < n_pay; i++) begin
         if (i < brk)
            stream_bytes.push_back((i == 0) ? DESIG_BYTE0 :
                                   (i == 1) ? DESIG_BYTE1 : DESIG_BYTE2);
         else
            stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   function automatic logic [7:0] pick_record();
      case ($urandom_range(0, 9))
         0, 1, 2: return 8'd1;
         3, 4, 5, 6: return 8'd2;
         7: return 8'd7;
         8: return 8'($urandom_range(8, 9));
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Favor numbers that sit in the table, plus some arbitrary ones.
   function automatic logic [7:0] pick_dataset(input logic [7:0] rec);
      if (rec == 8'd1 && $urandom_range(0, 2) == 0) return 8'd90;
      case ($urandom_range(0, 15))
         0: return 8'd0;
         1: return 8'd5;
         2: return 8'd10;
         3: return 8'd20;
         4: return 8'd22;
         5: return 8'd90;
         6: return 8'd95;
         7: return 8'd120;
         8: return 8'd122;
         9: return 8'd125;
         10: return 8'd200;
         11: return 8'd201;
         12: return 8'd202;
         13: return 8'd154;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Build a stream of random datasets, possibly cut short by a huge or overflowing
   // length, then end it cleanly, with padding, with a truncation, with a bad marker,
   // mid-dataset or with noise.
   task automatic build_random_stream();
      int          n_sets;
      int          ext;
      logic [63:0] len;
      logic [7:0]  rec, ds;
      bit          cut;
      int          keep;
      stream_bytes.delete();
      n_sets = $urandom_range(1, 5);
      cut = 1'b0;
      for (int k = 0; k < n_sets && !cut; k++) begin
         rec = pick_record();
         ds  = pick_dataset(rec);
         ext = -1;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6, 7: len = 64'($urandom_range(1, 6));
            8, 9, 10: len = 64'd2;
            11: len = 64'd0;
            12, 13: begin
               ext = $urandom_range(1, 3);
               len = 64'($urandom_range(0, 255));
            end
            14: begin
               ext = 0;
               len = 64'd0;
            end
            15: len = 64'($urandom_range(7, 40));
            16: begin
               // near or at the widest length; the stream ends inside the payload
               ext = 6;
               len = $urandom_range(0, 1) ? 64'hFFFF_FFFF_FFFF :
                     ({$urandom(), $urandom()} & 64'hFFFF_FFFF_FFFF) | 64'h100;
               cut = 1'b1;
            end
            17: begin
               len = 64'h7FFF;
               cut = 1'b1;
            end
            18: begin
               // length bytes that nearly always reach 2^48, giving a length error
               ext = $urandom_range(7, 9);
               len = {$urandom(), $urandom()} | (64'h1 << (8 * ext - 8));
               cut = 1'b1;
            end
            default: len = 64'($urandom_range(1, 3));
         endcase
         add_dataset(rec, ds, len, ext, 6);
      end
      if (cut) begin
         repeat ($urandom_range(0, 2)) stream_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 9))
            5: stream_bytes.push_back(8'h00);
            6: begin
               stream_bytes.push_back(8'h00);
               repeat ($urandom_range(1, 3))
                  stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
            7: begin
               stream_bytes.push_back(8'($urandom_range(1, 255)));
               repeat ($urandom_range(0, 3))
                  stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
            8: begin
               // cut the stream at a random byte, possibly keeping it whole
               keep = $urandom_range(1, stream_bytes.size());
               while (stream_bytes.size() > keep) void'(stream_bytes.pop_back());
            end
            9: begin
               repeat ($urandom_range(1, 4))
                  stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
            default: ;
         endcase
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_directed_streams();
      set_idling(0, 0);
      // Zero before any dataset is a bad marker; the next byte is ignored.
      stream_bytes = '{8'h00, 8'h55};
      send_stream();
      // Charset designation ESC % G, a 16-bit value in record 2 (text in
      // UTF-8 from here on), then padding on the last byte.
      stream_bytes = '{MARKER_BYTE, 8'h01, 8'h5A, 8'h00, 8'h03,
                       DESIG_BYTE0, DESIG_BYTE1, DESIG_BYTE2,
                       MARKER_BYTE, 8'h02, 8'h00, 8'h00, 8'h02, 8'hAB, 8'hCD,
                       8'h00};
      send_stream();
      // Extended length with no length bytes, then a zero that is not the
      // last byte (truncation), then an ignored byte.
      stream_bytes = '{MARKER_BYTE, 8'h02, 8'h78, 8'h80, 8'h00, 8'h00, 8'hFF};
      send_stream();
      // Length word 0xFFFF, then length bytes reaching 2^48: length error.
      stream_bytes = '{MARKER_BYTE, 8'h09, 8'h0A, 8'hFF, 8'hFF, 8'h01,
                       8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
      send_stream();
   endtask

   task automatic test_random_streams(input int items, input int sender_pct,
                                      input int receiver_pct);
      int sent;
      sent = 0;
      set_idling(sender_pct, receiver_pct);
      while (sent < items) begin
         build_random_stream();
         sent += stream_bytes.size();
         send_stream();
      end
   endtask

   // Hold the result side off for a long stretch while bytes keep coming, so
   // the parser fills up and drops req_ready.
   task automatic test_output_stall();
      int sent;
      sent = 0;
      set_idling(0, 0);
      hold_off_left <= 100;
      while (sent < 40) begin
         build_random_stream();
         sent += stream_bytes.size();
         send_stream();
      end
   endtask

   // Pause the sender until the parser has answered every byte, a few times.
   task automatic test_drain_pause();
      set_idling(0, 20);
      repeat (3) begin
         build_random_stream();
         send_stream();
         wait_drained();
      end
   endtask

   initial begin
      parser_clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_streams();
      test_random_streams(300, 0, 0);
      test_output_stall();
      test_random_streams(300, 45, 0);
      test_drain_pause();
      test_random_streams(300, 0, 45);
      test_random_streams(260, 6, 6);
      wait_drained();
      // let any stray result surface before judging
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog well beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
